// ===== rtl/bezier_path_flattener_defines.svh =====
// Assertion helpers shared by the flattener RTL.
`ifndef BEZIER_PATH_FLATTENER_DEFINES_SVH
`define BEZIER_PATH_FLATTENER_DEFINES_SVH

// Property that must hold at every clock edge outside reset.
`define BPF_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Condition that must never be seen outside reset.
`define BPF_NEVER(lbl, clk, rstn, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);

`endif

// ===== rtl/bpf_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package bpf_pkg;

    localparam int COORD_W    = 32;
    localparam int T_W        = 17;
    localparam int CMD_W      = 3;
    localparam int TOL_W      = 31;
    localparam int DEPTH_W    = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int IN_DATA_W  = 192;
    localparam int OUT_DATA_W = 88;
    localparam int DIV_W      = 36;

    localparam int DEPTH_LIMIT_DEF    = 6;
    localparam int FIXED_SEGMENTS_DEF = 16;
    localparam int COORD_BITS_DEF     = 32;
    localparam int QUEUE_DEPTH        = 2;

    // path command codes
    localparam logic [CMD_W-1:0] CMD_MOVE  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_LINE  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_CUBIC = 3'd2;
    localparam logic [CMD_W-1:0] CMD_QUAD  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_CLOSE = 3'd4;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ADAPTIVE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TOL      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DEPTH    = 2'd2;

    localparam logic               RST_ADAPTIVE = 1'b1;
    localparam logic [TOL_W-1:0]   RST_TOL      = 31'd6554;
    localparam logic [DEPTH_W-1:0] RST_DEPTH    = 3'd6;

    localparam logic [T_W-1:0] T_ONE = 17'h10000;

    // one segment handed from the front to the back
    typedef struct packed {
        logic                          is_curve;
        logic [3:0][COORD_W-1:0]       px;
        logic [3:0][COORD_W-1:0]       py;
    } seg_entry_t;

    typedef struct packed {
        logic               adaptive;
        logic [TOL_W-1:0]   tol;
        logic [DEPTH_W-1:0] depth;
    } cfg_t;

    // a + round((b - a) * t / 65536)
    function automatic logic [COORD_W-1:0] lerp(input logic [COORD_W-1:0] a,
                                                input logic [COORD_W-1:0] b,
                                                input logic [T_W-1:0] t);
        logic signed [COORD_W:0] d;
        logic signed [50:0]      p;
        d = $signed({b[COORD_W-1], b}) - $signed({a[COORD_W-1], a});
        p = d * $signed({1'b0, t});
        p = p + 51'sd32768;
        return a + COORD_W'(p >>> 16);
    endfunction

    // floor((a + b) / 2)
    function automatic logic [COORD_W-1:0] mid(input logic [COORD_W-1:0] a,
                                               input logic [COORD_W-1:0] b);
        logic [COORD_W:0] s;
        s = {a[COORD_W-1], a} + {b[COORD_W-1], b};
        return s[COORD_W:1];
    endfunction

    // de Casteljau split at one half: [3:0] left piece, [7:4] right piece
    function automatic logic [7:0][COORD_W-1:0] halve(input logic [3:0][COORD_W-1:0] p);
        logic [COORD_W-1:0] a, b, c, d, e, s;
        a = mid(p[0], p[1]);
        b = mid(p[1], p[2]);
        c = mid(p[2], p[3]);
        d = mid(a, b);
        e = mid(b, c);
        s = mid(d, e);
        return {p[3], c, e, s, s, d, a, p[0]};
    endfunction

endpackage

`default_nettype wire

// ===== rtl/bezier_path_flattener.sv =====
// Channel   Dir  Payload (low bit up)                                        Marker
// s_*       in   tdata: ctrl1_x ctrl1_y ctrl2_x ctrl2_y end_x end_y         tuser: command
// m_*       out  tdata: vert_x vert_y param_t (zero padded to 88 bits)       tlast: last_vertex
// cfg_*     in   cfg_index 0 adaptive_mode, 1 flat_tolerance, 2 max_depth    write only
//
// Line and close (unless at the start): 2 vertices, one per cycle while m_tready holds.
// Quadratic: divide by three in the front. Fixed sampling: FIXED_SEGMENTS+1 vertices, each
// six lerp steps + emit. Adaptive: up to 127 tested pieces at depth six, a vertex per leaf.
// Reset loads register defaults and empties the queue; the split stack needs no clearing.
// A two-entry queue lets the front take commands while the back is still flattening.
`timescale 1ns / 1ps
`default_nettype none

module bezier_path_flattener
    import bpf_pkg::*;
#(
    parameter int DEPTH_LIMIT    = DEPTH_LIMIT_DEF,
    parameter int FIXED_SEGMENTS = FIXED_SEGMENTS_DEF,
    parameter int COORD_BITS     = COORD_BITS_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [IN_DATA_W-1:0]  s_tdata,   // ctrl1_x ctrl1_y ctrl2_x ctrl2_y end_x end_y
    input  wire logic [CMD_W-1:0]      s_tuser,   // command
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [OUT_DATA_W-1:0]      m_tdata,   // vert_x vert_y param_t
    output logic                       m_tlast,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [TOL_W-1:0]      cfg_wdata
);

    cfg_t       cfg_reg, cfg_next;
    logic       q_push, q_pop, q_full, q_empty;
    seg_entry_t q_wdata, q_rdata;

    // configuration registers
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_ADAPTIVE: cfg_next.adaptive = cfg_wdata[0];
                CFG_TOL:      cfg_next.tol      = cfg_wdata;
                CFG_DEPTH:    cfg_next.depth    = cfg_wdata[DEPTH_W-1:0];
                default:      cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.adaptive <= RST_ADAPTIVE;
            cfg_reg.tol      <= RST_TOL;
            cfg_reg.depth    <= RST_DEPTH;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    bpf_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_push   (q_push),
        .q_data   (q_wdata),
        .q_full   (q_full)
    );

    bpf_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_wdata),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_rdata),
        .empty     (q_empty)
    );

    bpf_back #(
        .DEPTH_LIMIT    (DEPTH_LIMIT),
        .FIXED_SEGMENTS (FIXED_SEGMENTS),
        .COORD_BITS     (COORD_BITS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .q_empty  (q_empty),
        .q_pop    (q_pop),
        .q_data   (q_rdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

`default_nettype wire

// ===== rtl/bpf_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none

`include "bezier_path_flattener_defines.svh"

module bpf_queue
    import bpf_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       push,
    input  seg_entry_t      push_data,
    output logic            full,
    input  wire logic       pop,
    output seg_entry_t      pop_data,
    output logic            empty
);

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    seg_entry_t      mem [QUEUE_DEPTH];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   count_reg, count_next;

    assign full     = (count_reg == CW'(QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = mem[rd_ptr_reg];

    // pointer and fill count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    `BPF_NEVER(a_q_overflow, clk, rst_n, push && full, "queue push while full")
    `BPF_NEVER(a_q_underflow, clk, rst_n, pop && empty, "queue pop while empty")

endmodule

`default_nettype wire

// ===== rtl/bpf_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module bpf_front
    import bpf_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [IN_DATA_W-1:0] s_tdata,
    input  wire logic [CMD_W-1:0]     s_tuser,
    output logic                      q_push,
    output seg_entry_t                q_data,
    input  wire logic                 q_full
);

    localparam logic F_IDLE = 1'b0;
    localparam logic F_DIV  = 1'b1;
    localparam int   DIV_STEPS = 2;
    localparam int   SW = $clog2(DIV_STEPS);
    localparam int   HALF_W = DIV_W / 2;
    localparam int   PROD_W = DIV_W + HALF_W;
    localparam int   ACC_W  = 2 * DIV_W;
    // offset that keeps every quadratic numerator positive
    localparam logic [DIV_W-1:0] DIV_BIAS = 36'hC_0000_0000;
    // (2^37 + 1) / 3: floor(u * RECIP3 / 2^37) equals floor(u / 3) for every 36-bit u
    localparam logic [DIV_W-1:0] RECIP3 = 36'd45812984491;

    logic                   state_reg, state_next;
    logic [COORD_W-1:0]     pen_x_reg, pen_x_next;
    logic [COORD_W-1:0]     pen_y_reg, pen_y_next;
    logic [COORD_W-1:0]     start_x_reg, start_x_next;
    logic [COORD_W-1:0]     start_y_reg, start_y_next;
    logic [SW-1:0]          cnt_reg, cnt_next;
    seg_entry_t             hold_reg, hold_next;
    logic [3:0][DIV_W-1:0]  u_reg, u_next;
    logic [3:0][ACC_W-1:0]  acc_reg, acc_next;

    logic [COORD_W-1:0]     c1x, c1y, c2x, c2y, ex, ey;
    logic                   accept;
    logic                   at_start;

    assign c1x = s_tdata[31:0];
    assign c1y = s_tdata[63:32];
    assign c2x = s_tdata[95:64];
    assign c2y = s_tdata[127:96];
    assign ex  = s_tdata[159:128];
    assign ey  = s_tdata[191:160];

    assign s_tready = (state_reg == F_IDLE) && !q_full;
    assign accept   = s_tvalid && s_tready;
    assign at_start = (pen_x_reg == start_x_reg) && (pen_y_reg == start_y_reg);

    // base + 2*ctl + 1, biased; floor of it over three gives the raised point
    function automatic logic [DIV_W-1:0] quad_num(input logic [COORD_W-1:0] base,
                                                  input logic [COORD_W-1:0] ctl);
        logic [DIV_W-1:0] b2, c2;
        b2 = {{(DIV_W-COORD_W){base[COORD_W-1]}}, base};
        c2 = {{(DIV_W-COORD_W-1){ctl[COORD_W-1]}}, ctl, 1'b0};
        return b2 + c2 + DIV_W'(1) + DIV_BIAS;
    endfunction

    // classify, update pen, run the divide-by-three for quadratics
    always_comb
    begin
        logic [PROD_W-1:0] prod;
        state_next   = state_reg;
        pen_x_next   = pen_x_reg;
        pen_y_next   = pen_y_reg;
        start_x_next = start_x_reg;
        start_y_next = start_y_reg;
        cnt_next     = cnt_reg;
        hold_next    = hold_reg;
        u_next       = u_reg;
        acc_next     = acc_reg;
        prod         = '0;
        q_push       = 1'b0;
        q_data       = hold_reg;

        case (state_reg)
            F_IDLE:
            begin
                q_data.is_curve = 1'b0;
                q_data.px       = {ex, c2x, c1x, pen_x_reg};
                q_data.py       = {ey, c2y, c1y, pen_y_reg};
                if (accept)
                begin
                    case (s_tuser)
                        CMD_MOVE:
                        begin
                            pen_x_next   = ex;
                            pen_y_next   = ey;
                            start_x_next = ex;
                            start_y_next = ey;
                        end
                        CMD_LINE:
                        begin
                            q_push     = 1'b1;
                            pen_x_next = ex;
                            pen_y_next = ey;
                        end
                        CMD_CUBIC:
                        begin
                            q_push          = 1'b1;
                            q_data.is_curve = 1'b1;
                            pen_x_next      = ex;
                            pen_y_next      = ey;
                        end
                        CMD_QUAD:
                        begin
                            hold_next.is_curve = 1'b1;
                            hold_next.px       = {ex, c2x, c1x, pen_x_reg};
                            hold_next.py       = {ey, c2y, c1y, pen_y_reg};
                            u_next[0]  = quad_num(pen_x_reg, c1x);
                            u_next[1]  = quad_num(pen_y_reg, c1y);
                            u_next[2]  = quad_num(ex, c1x);
                            u_next[3]  = quad_num(ey, c1y);
                            cnt_next   = '0;
                            pen_x_next = ex;
                            pen_y_next = ey;
                            state_next = F_DIV;
                        end
                        CMD_CLOSE:
                        begin
                            q_push    = !at_start;
                            q_data.px = {start_x_reg, c2x, c1x, pen_x_reg};
                            q_data.py = {start_y_reg, c2y, c1y, pen_y_reg};
                            pen_x_next = start_x_reg;
                            pen_y_next = start_y_reg;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            F_DIV:
            begin
                // reciprocal multiply, low half of the numerator first, then the high half
                for (int k = 0; k < 4; k++)
                begin
                    if (cnt_reg == '0)
                    begin
                        prod        = u_reg[k][HALF_W-1:0] * RECIP3;
                        acc_next[k] = {{(ACC_W-PROD_W){1'b0}}, prod};
                    end
                    else
                    begin
                        prod        = u_reg[k][DIV_W-1:HALF_W] * RECIP3;
                        acc_next[k] = acc_reg[k] + {prod, {HALF_W{1'b0}}};
                    end
                end
                cnt_next    = cnt_reg + 1'b1;
                q_data.px[1] = acc_next[0][DIV_W+COORD_W:DIV_W+1];
                q_data.py[1] = acc_next[1][DIV_W+COORD_W:DIV_W+1];
                q_data.px[2] = acc_next[2][DIV_W+COORD_W:DIV_W+1];
                q_data.py[2] = acc_next[3][DIV_W+COORD_W:DIV_W+1];
                if (cnt_reg == SW'(DIV_STEPS - 1))
                begin
                    q_push     = 1'b1;
                    state_next = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= F_IDLE;
            pen_x_reg   <= '0;
            pen_y_reg   <= '0;
            start_x_reg <= '0;
            start_y_reg <= '0;
            cnt_reg     <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            pen_x_reg   <= pen_x_next;
            pen_y_reg   <= pen_y_next;
            start_x_reg <= start_x_next;
            start_y_reg <= start_y_next;
            cnt_reg     <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hold_reg <= hold_next;
        u_reg    <= u_next;
        acc_reg  <= acc_next;
    end

endmodule

`default_nettype wire

// ===== rtl/bpf_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

`include "bezier_path_flattener_defines.svh"

module bpf_back
    import bpf_pkg::*;
#(
    parameter int DEPTH_LIMIT    = DEPTH_LIMIT_DEF,
    parameter int FIXED_SEGMENTS = FIXED_SEGMENTS_DEF,
    parameter int COORD_BITS     = COORD_BITS_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  cfg_t                       cfg,
    input  wire logic                  q_empty,
    output logic                       q_pop,
    input  seg_entry_t                 q_data,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [OUT_DATA_W-1:0]      m_tdata,
    output logic                       m_tlast
);

    localparam logic [3:0] B_IDLE  = 4'd0;
    localparam logic [3:0] B_LINE0 = 4'd1;
    localparam logic [3:0] B_LINE1 = 4'd2;
    localparam logic [3:0] B_FIX   = 4'd3;
    localparam logic [3:0] B_FEMIT = 4'd4;
    localparam logic [3:0] B_ATEST = 4'd5;
    localparam logic [3:0] B_ADEC  = 4'd6;
    localparam logic [3:0] B_AEMIT = 4'd7;

    localparam int SPW   = $clog2(DEPTH_LIMIT + 1);
    localparam int NSTK  = 2 ** SPW;
    localparam int IW    = $clog2(FIXED_SEGMENTS + 1);
    localparam int RW    = $clog2(FIXED_SEGMENTS);
    localparam int Q_INC = 65536 / FIXED_SEGMENTS;
    localparam int R_INC = 65536 % FIXED_SEGMENTS;

    localparam longint SAT_HI_L = (longint'(1) <<< (COORD_BITS - 1)) - 1;
    localparam logic signed [COORD_W-1:0] SAT_HI = COORD_W'(SAT_HI_L);
    localparam logic signed [COORD_W-1:0] SAT_LO = COORD_W'(-SAT_HI_L - 1);

    typedef struct packed {
        logic [3:0][COORD_W-1:0] px;
        logic [3:0][COORD_W-1:0] py;
        logic [T_W-1:0]          t0;
        logic [DEPTH_W-1:0]      dep;
    } piece_t;

    function automatic logic [COORD_W-1:0] sat(input logic [COORD_W-1:0] v);
        if ($signed(v) > SAT_HI)
        begin
            return SAT_HI;
        end
        else if ($signed(v) < SAT_LO)
        begin
            return SAT_LO;
        end
        return v;
    endfunction

    logic [3:0]             state_reg, state_next;
    seg_entry_t             seg_reg, seg_next;
    piece_t                 cur_reg, cur_next;
    piece_t                 stack [NSTK];
    logic [SPW-1:0]         sp_reg, sp_next;
    logic                   stk_we;
    piece_t                 stk_wdata;

    logic [2:0]             step_reg, step_next;
    logic [IW-1:0]          idx_reg, idx_next;
    logic [T_W-1:0]         tq_reg, tq_next;
    logic [RW-1:0]          tr_reg, tr_next;
    logic [4:0][COORD_W-1:0] lx_reg, lx_next, ly_reg, ly_next;
    logic [COORD_W-1:0]     fx_reg, fx_next, fy_reg, fy_next;

    logic [61:0]            sqx_reg, sqx_next, sqy_reg, sqy_next;
    logic [61:0]            tolsq_reg, tolsq_next;
    logic                   far_reg, far_next;
    logic                   deep_reg, deep_next;

    logic                   ovalid_reg, ovalid_next;
    logic [COORD_W-1:0]     ox_reg, ox_next, oy_reg, oy_next;
    logic [T_W-1:0]         ot_reg, ot_next;
    logic                   olast_reg, olast_next;

    logic                   slot_free;
    logic [DEPTH_W-1:0]     md;

    assign slot_free = !ovalid_reg || m_tready;
    assign md = (cfg.depth > DEPTH_W'(DEPTH_LIMIT)) ? DEPTH_W'(DEPTH_LIMIT) : cfg.depth;

    assign m_tvalid = ovalid_reg;
    assign m_tdata  = {{(OUT_DATA_W - 2*COORD_W - T_W){1'b0}}, ot_reg, oy_reg, ox_reg};
    assign m_tlast  = olast_reg;

    // sequencer for lines, fixed sampling and midpoint splitting
    always_comb
    begin
        logic [COORD_W-1:0]  ax, bx, ay, by;
        logic signed [COORD_W:0] dfx, dfy;
        logic [COORD_W:0]    absx, absy;
        logic [7:0][COORD_W-1:0] hx, hy;
        logic [RW:0]         rsum;
        logic                load_out;
        logic                leaf;

        state_next  = state_reg;
        seg_next    = seg_reg;
        cur_next    = cur_reg;
        sp_next     = sp_reg;
        stk_we      = 1'b0;
        stk_wdata   = cur_reg;
        step_next   = step_reg;
        idx_next    = idx_reg;
        tq_next     = tq_reg;
        tr_next     = tr_reg;
        lx_next     = lx_reg;
        ly_next     = ly_reg;
        fx_next     = fx_reg;
        fy_next     = fy_reg;
        sqx_next    = sqx_reg;
        sqy_next    = sqy_reg;
        tolsq_next  = tolsq_reg;
        far_next    = far_reg;
        deep_next   = deep_reg;
        ox_next     = ox_reg;
        oy_next     = oy_reg;
        ot_next     = ot_reg;
        olast_next  = olast_reg;
        q_pop       = 1'b0;
        load_out    = 1'b0;
        ax = '0; bx = '0; ay = '0; by = '0;
        dfx = '0; dfy = '0; absx = '0; absy = '0;
        hx = '0; hy = '0; rsum = '0; leaf = 1'b0;

        case (state_reg)
            B_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop    = 1'b1;
                    seg_next = q_data;
                    if (!q_data.is_curve)
                    begin
                        state_next = B_LINE0;
                    end
                    else if (cfg.adaptive)
                    begin
                        cur_next.px  = q_data.px;
                        cur_next.py  = q_data.py;
                        cur_next.t0  = '0;
                        cur_next.dep = '0;
                        sp_next      = '0;
                        state_next   = B_ATEST;
                    end
                    else
                    begin
                        step_next  = '0;
                        idx_next   = '0;
                        tq_next    = '0;
                        tr_next    = '0;
                        state_next = B_FIX;
                    end
                end
            end
            B_LINE0:
            begin
                if (slot_free)
                begin
                    load_out   = 1'b1;
                    ox_next    = sat(seg_reg.px[0]);
                    oy_next    = sat(seg_reg.py[0]);
                    ot_next    = '0;
                    olast_next = 1'b0;
                    state_next = B_LINE1;
                end
            end
            B_LINE1:
            begin
                if (slot_free)
                begin
                    load_out   = 1'b1;
                    ox_next    = sat(seg_reg.px[3]);
                    oy_next    = sat(seg_reg.py[3]);
                    ot_next    = T_ONE;
                    olast_next = 1'b1;
                    state_next = B_IDLE;
                end
            end
            B_FIX:
            begin
                // one interpolation per axis per cycle, three levels deep
                case (step_reg)
                    3'd0:
                    begin
                        ax = seg_reg.px[0]; bx = seg_reg.px[1];
                        ay = seg_reg.py[0]; by = seg_reg.py[1];
                    end
                    3'd1:
                    begin
                        ax = seg_reg.px[1]; bx = seg_reg.px[2];
                        ay = seg_reg.py[1]; by = seg_reg.py[2];
                    end
                    3'd2:
                    begin
                        ax = seg_reg.px[2]; bx = seg_reg.px[3];
                        ay = seg_reg.py[2]; by = seg_reg.py[3];
                    end
                    3'd3:
                    begin
                        ax = lx_reg[0]; bx = lx_reg[1];
                        ay = ly_reg[0]; by = ly_reg[1];
                    end
                    3'd4:
                    begin
                        ax = lx_reg[1]; bx = lx_reg[2];
                        ay = ly_reg[1]; by = ly_reg[2];
                    end
                    default:
                    begin
                        ax = lx_reg[3]; bx = lx_reg[4];
                        ay = ly_reg[3]; by = ly_reg[4];
                    end
                endcase
                if (step_reg == 3'd5)
                begin
                    fx_next    = lerp(ax, bx, tq_reg);
                    fy_next    = lerp(ay, by, tq_reg);
                    state_next = B_FEMIT;
                end
                else
                begin
                    lx_next[step_reg] = lerp(ax, bx, tq_reg);
                    ly_next[step_reg] = lerp(ay, by, tq_reg);
                    step_next = step_reg + 1'b1;
                end
            end
            B_FEMIT:
            begin
                if (slot_free)
                begin
                    load_out   = 1'b1;
                    ox_next    = sat(fx_reg);
                    oy_next    = sat(fy_reg);
                    ot_next    = tq_reg;
                    olast_next = (idx_reg == IW'(FIXED_SEGMENTS));
                    if (idx_reg == IW'(FIXED_SEGMENTS))
                    begin
                        state_next = B_IDLE;
                    end
                    else
                    begin
                        // next t = floor(i * 65536 / segments), kept as quotient and remainder
                        rsum = {1'b0, tr_reg} + (RW+1)'(R_INC);
                        if (rsum >= (RW+1)'(FIXED_SEGMENTS))
                        begin
                            tr_next = RW'(rsum - (RW+1)'(FIXED_SEGMENTS));
                            tq_next = tq_reg + T_W'(Q_INC + 1);
                        end
                        else
                        begin
                            tr_next = rsum[RW-1:0];
                            tq_next = tq_reg + T_W'(Q_INC);
                        end
                        idx_next   = idx_reg + 1'b1;
                        step_next  = '0;
                        state_next = B_FIX;
                    end
                end
            end
            B_ATEST:
            begin
                // chord extents and their squares
                dfx  = $signed({cur_reg.px[3][COORD_W-1], cur_reg.px[3]})
                     - $signed({cur_reg.px[0][COORD_W-1], cur_reg.px[0]});
                dfy  = $signed({cur_reg.py[3][COORD_W-1], cur_reg.py[3]})
                     - $signed({cur_reg.py[0][COORD_W-1], cur_reg.py[0]});
                absx = dfx[COORD_W] ? (COORD_W+1)'(-dfx) : dfx;
                absy = dfy[COORD_W] ? (COORD_W+1)'(-dfy) : dfy;
                far_next   = (absx >= {2'b00, cfg.tol}) || (absy >= {2'b00, cfg.tol});
                sqx_next   = absx[TOL_W-1:0] * absx[TOL_W-1:0];
                sqy_next   = absy[TOL_W-1:0] * absy[TOL_W-1:0];
                tolsq_next = cfg.tol * cfg.tol;
                deep_next  = (cur_reg.dep >= md);
                state_next = B_ADEC;
            end
            B_ADEC:
            begin
                leaf = deep_reg || (!far_reg && ({1'b0, sqx_reg} + {1'b0, sqy_reg}
                                                  < {1'b0, tolsq_reg}));
                if (leaf)
                begin
                    state_next = B_AEMIT;
                end
                else
                begin
                    // keep the left half, park the right half
                    hx = halve(cur_reg.px);
                    hy = halve(cur_reg.py);
                    stk_we        = 1'b1;
                    stk_wdata.px  = hx[7:4];
                    stk_wdata.py  = hy[7:4];
                    stk_wdata.t0  = cur_reg.t0 + (T_ONE >> (cur_reg.dep + 1'b1));
                    stk_wdata.dep = cur_reg.dep + 1'b1;
                    sp_next       = sp_reg + 1'b1;
                    cur_next.px   = hx[3:0];
                    cur_next.py   = hy[3:0];
                    cur_next.dep  = cur_reg.dep + 1'b1;
                    state_next    = B_ATEST;
                end
            end
            B_AEMIT:
            begin
                if (slot_free)
                begin
                    load_out   = 1'b1;
                    ox_next    = sat(cur_reg.px[0]);
                    oy_next    = sat(cur_reg.py[0]);
                    ot_next    = cur_reg.t0;
                    olast_next = (sp_reg == '0);
                    if (sp_reg == '0)
                    begin
                        state_next = B_IDLE;
                    end
                    else
                    begin
                        cur_next   = stack[sp_reg - 1'b1];
                        sp_next    = sp_reg - 1'b1;
                        state_next = B_ATEST;
                    end
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase

        ovalid_next = load_out ? 1'b1 : (m_tready ? 1'b0 : ovalid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= B_IDLE;
            sp_reg     <= '0;
            step_reg   <= '0;
            idx_reg    <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            sp_reg     <= sp_next;
            step_reg   <= step_next;
            idx_reg    <= idx_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        seg_reg   <= seg_next;
        cur_reg   <= cur_next;
        tq_reg    <= tq_next;
        tr_reg    <= tr_next;
        lx_reg    <= lx_next;
        ly_reg    <= ly_next;
        fx_reg    <= fx_next;
        fy_reg    <= fy_next;
        sqx_reg   <= sqx_next;
        sqy_reg   <= sqy_next;
        tolsq_reg <= tolsq_next;
        far_reg   <= far_next;
        deep_reg  <= deep_next;
        ox_reg    <= ox_next;
        oy_reg    <= oy_next;
        ot_reg    <= ot_next;
        olast_reg <= olast_next;
    end

    // pending right halves
    always_ff @(posedge clk)
    begin
        if (stk_we)
        begin
            stack[sp_reg] <= stk_wdata;
        end
    end

    `BPF_ASSERT(a_idle_stack_empty, clk, rst_n, (state_reg != B_IDLE) || (sp_reg == '0), "split stack not drained at end of curve")
    `BPF_ASSERT(a_depth_bound, clk, rst_n, (state_reg == B_ATEST) |-> (cur_reg.dep <= md), "piece deeper than depth limit")
    `BPF_ASSERT(a_line_end, clk, rst_n, ($past(state_reg) == B_LINE1 && state_reg == B_IDLE) |-> (olast_reg && ot_reg == T_ONE), "line end vertex not marked last")

endmodule

`default_nettype wire
